// ===== rtl/tmpwm_pkg.sv =====
// shared types and constants for the two-motor byte-pair pwm block
package tmpwm_pkg;

  localparam logic [15:0] PERIOD_RESET  = 16'd13616;
  localparam logic [15:0] COMPARE_RESET = 16'd3404;

  // opcode of an input word
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // x / 252 is (x >> 2) / 63; the /63 uses floor(2^28 / 63) plus one correction step
  localparam int unsigned RecipShift = 28;
  localparam logic [22:0] RECIP_63   = 23'd4260880;
  localparam logic [5:0]  DIV_ODD    = 6'd63;
  localparam logic [15:0] SAT16      = 16'hFFFF;

  // one motor's drive term: byte distance from the midpoint, or the midpoint wrap case
  typedef struct packed {
    logic       neg;
    logic [7:0] off;
  } lane_t;

  // what travels beside the multipliers for one word
  typedef struct packed {
    logic [15:0] cnt;
    logic        upd;
    logic        dir_l;
    logic        dir_r;
  } meta_t;

endpackage

// ===== rtl/tmpwm_pair.sv =====
// byte pairing, motor split, direction and offset decode, and the period counter
module tmpwm_pair import tmpwm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        opcode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [15:0] period_i,
  output meta_t       meta_o,
  output lane_t       lane_l_o,
  output lane_t       lane_r_o
);

  logic [7:0]  first_q, first_d, second_q, second_d;
  logic [7:0]  first_n, second_n, byte_l, byte_r;
  logic        held_q, held_d, pair_done;
  logic [15:0] cnt_q, cnt_d;
  logic [16:0] cnt_inc;
  lane_t       lane_l, lane_r;
  logic        dir_l, dir_r;
  meta_t       meta_q;
  lane_t       lane_l_q, lane_r_q;

  always_comb begin
    first_n  = first_q;
    second_n = second_q;
    first_d  = first_q;
    second_d = second_q;
    held_d   = held_q;
    cnt_d    = cnt_q;
    cnt_inc  = {1'b0, cnt_q} + 17'd1;
    pair_done = 1'b0;
    if (opcode_i == OP_BYTE) begin
      if (first_q == 8'd0 && second_q == 8'd0) begin
        first_n = rx_byte_i;
      end else begin
        second_n = rx_byte_i;
      end
      if (!held_q) begin
        held_d   = 1'b1;
        first_d  = first_n;
        second_d = second_n;
      end else begin
        held_d    = 1'b0;
        pair_done = 1'b1;
        first_d   = 8'd0;
        second_d  = 8'd0;
      end
    end else begin
      cnt_d = (cnt_inc >= {1'b0, period_i}) ? 16'd0 : cnt_inc[15:0];
    end
  end

  // an odd first byte drives the left motor
  assign byte_l = first_n[0] ? first_n  : second_n;
  assign byte_r = first_n[0] ? second_n : first_n;

  // left midpoint sits at 128, right at 127
  always_comb begin
    lane_l.neg = 1'b0;
    if (byte_l > 8'd127) begin
      dir_l      = 1'b1;
      lane_l.neg = (byte_l == 8'd128);
      lane_l.off = 8'({byte_l, 1'b0} - 9'd257);
    end else begin
      dir_l      = 1'b0;
      lane_l.off = 8'(9'd255 - {byte_l, 1'b0});
    end
    lane_r.neg = 1'b0;
    if (byte_r > 8'd126) begin
      dir_r      = 1'b1;
      lane_r.neg = (byte_r == 8'd127);
      lane_r.off = 8'({byte_r, 1'b0} - 9'd255);
    end else begin
      dir_r      = 1'b0;
      lane_r.off = 8'(9'd253 - {byte_r, 1'b0});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= 8'd0;
      second_q <= 8'd0;
      held_q   <= 1'b0;
      cnt_q    <= 16'd0;
    end else if (accept_i) begin
      first_q  <= first_d;
      second_q <= second_d;
      held_q   <= held_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      meta_q.cnt   <= cnt_d;
      meta_q.upd   <= pair_done;
      meta_q.dir_l <= dir_l;
      meta_q.dir_r <= dir_r;
      lane_l_q     <= lane_l;
      lane_r_q     <= lane_r;
    end
  end

  assign meta_o   = meta_q;
  assign lane_l_o = lane_l_q;
  assign lane_r_o = lane_r_q;

endmodule

// ===== rtl/tmpwm_scale.sv =====
// period * offset / 252 with saturation (zero for the wrap case), two register stages and a final correction
module tmpwm_scale import tmpwm_pkg::*; (
  input  logic        clk_i,
  input  logic        adv_i,
  input  logic [15:0] period_i,
  input  lane_t       lane_i,
  output logic [15:0] compare_o
);

  logic [23:0] prod_q;
  logic        neg_b_q, neg_c_q;
  logic [21:0] y_q;
  logic [16:0] q0_q;
  logic [44:0] recip_prod;
  logic [22:0] q0_x63, rem;
  logic [16:0] quot;

  assign recip_prod = 45'(prod_q[23:2]) * 45'(RECIP_63);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q  <= 24'(period_i) * 24'(lane_i.off);
      neg_b_q <= lane_i.neg;
      y_q     <= prod_q[23:2];
      q0_q    <= recip_prod[RecipShift +: 17];
      neg_c_q <= neg_b_q;
    end
  end

  // estimate is exact or one short
  always_comb begin
    q0_x63 = {q0_q, 6'd0} - 23'(q0_q);
    rem    = 23'(y_q) - q0_x63;
    quot   = (rem >= 23'(DIV_ODD)) ? q0_q + 17'd1 : q0_q;
    if (neg_c_q) begin
      compare_o = 16'd0;
    end else if (quot[16]) begin
      compare_o = SAT16;
    end else begin
      compare_o = quot[15:0];
    end
  end

endmodule

// ===== rtl/two_motor_pwm_from_byte_pair.sv =====
// two-motor pwm block fed by byte pairs and timer ticks: pipeline control and outputs
// throughput: one word per cycle; the pipeline stalls only while a result waits
// the pipeline is the decode register, the period multiplier, the /63 reciprocal
// multiplier, then the correction feeding the compare and output registers
// reset: period 13616, both compares 3404, directions, slots and counter cleared
module two_motor_pwm_from_byte_pair import tmpwm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        pwm_left_o,
  output logic        pwm_right_o,
  output logic        dir_left_o,
  output logic        dir_right_o,
  output logic [15:0] duty_left_o,
  output logic [15:0] duty_right_o
);

  logic        adv, accept;
  logic [15:0] period_q;
  logic        v1_q, v2_q, v3_q, out_valid_q;
  meta_t       meta1, meta2_q, meta3_q;
  lane_t       lane_l, lane_r;
  logic [15:0] cmp_l_new, cmp_r_new;
  logic [15:0] cmp_l_q, cmp_l_d, cmp_r_q, cmp_r_d;
  logic        dir_l_q, dir_l_d, dir_r_q, dir_r_d;
  logic        pwm_l_q, pwm_r_q;
  logic        load_out;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;
  assign load_out   = adv && v3_q;

  tmpwm_pair u_pair (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .opcode_i  (opcode_i),
    .rx_byte_i (rx_byte_i),
    .period_i  (period_q),
    .meta_o    (meta1),
    .lane_l_o  (lane_l),
    .lane_r_o  (lane_r)
  );

  tmpwm_scale u_scale_l (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .period_i  (period_q),
    .lane_i    (lane_l),
    .compare_o (cmp_l_new)
  );

  tmpwm_scale u_scale_r (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .period_i  (period_q),
    .lane_i    (lane_r),
    .compare_o (cmp_r_new)
  );

  // compares and directions change only for a word that completes a byte pair, as that word reaches the output
  always_comb begin
    cmp_l_d = cmp_l_q;
    cmp_r_d = cmp_r_q;
    dir_l_d = dir_l_q;
    dir_r_d = dir_r_q;
    if (meta3_q.upd) begin
      cmp_l_d = cmp_l_new;
      cmp_r_d = cmp_r_new;
      dir_l_d = meta3_q.dir_l;
      dir_r_d = meta3_q.dir_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RESET;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      cmp_l_q     <= COMPARE_RESET;
      cmp_r_q     <= COMPARE_RESET;
      dir_l_q     <= 1'b0;
      dir_r_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (adv) begin
        v1_q        <= in_valid_i;
        v2_q        <= v1_q;
        v3_q        <= v2_q;
        out_valid_q <= v3_q;
      end
      if (load_out) begin
        cmp_l_q <= cmp_l_d;
        cmp_r_q <= cmp_r_d;
        dir_l_q <= dir_l_d;
        dir_r_q <= dir_r_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta2_q <= meta1;
      meta3_q <= meta2_q;
    end
    if (load_out) begin
      pwm_l_q <= (meta3_q.cnt < cmp_l_d);
      pwm_r_q <= (meta3_q.cnt < cmp_r_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pwm_left_o   = pwm_l_q;
  assign pwm_right_o  = pwm_r_q;
  assign dir_left_o   = dir_l_q;
  assign dir_right_o  = dir_r_q;
  assign duty_left_o  = cmp_l_q;
  assign duty_right_o = cmp_r_q;

endmodule
